// ===== design/gps_pkg.sv =====
// Shared types, register codes and window table arithmetic for the granular pitch shifter.
package gps_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int PH_FRAC    = 12;
    localparam int PHASE_W    = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [16:0] WET_FULL = 17'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WET_LEVEL      = 3'd0,
        REG_PITCH_STEP     = 3'd1,
        REG_GRAIN_LENGTH   = 3'd2,
        REG_SPAWN_INTERVAL = 3'd3,
        REG_OVERLAP_GAIN   = 3'd4,
        REG_LENGTH_RECIP   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [16:0] wet_level;
        logic [14:0] pitch_step;
        logic [13:0] grain_length;
        logic [15:0] spawn_interval;
        logic [15:0] overlap_gain;
        logic [23:0] length_reciprocal;
    } t_cfg;

    localparam logic [16:0] RST_WET_LEVEL      = 17'd32768;
    localparam logic [14:0] RST_PITCH_STEP     = 15'd4096;
    localparam logic [13:0] RST_GRAIN_LENGTH   = 14'd4410;
    localparam logic [15:0] RST_SPAWN_INTERVAL = 16'd1103;
    localparam logic [15:0] RST_OVERLAP_GAIN   = 16'd23170;
    localparam logic [23:0] RST_LENGTH_RECIP   = 24'd3804;

    // sin^2(pi*k/D) in Q1.15 by a Q30 Taylor series; D = 2^wb
    function automatic logic [15:0] hann_entry(input logic [31:0] k, input int wb);
        logic [63:0] one_q30;
        logic [63:0] pi_q30;
        logic [63:0] x;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] w;
        one_q30 = 64'd1 << 30;
        pi_q30  = 64'd3373259426;
        x = {32'd0, k} << (30 - wb);
        if (x > (one_q30 >> 1)) begin
            x = one_q30 - x;
        end
        u  = (x * pi_q30) >> 30;
        u2 = (u * u) >> 30;
        t  = one_q30 - u2 / 110;
        t  = one_q30 - ((u2 * t) >> 30) / 72;
        t  = one_q30 - ((u2 * t) >> 30) / 42;
        t  = one_q30 - ((u2 * t) >> 30) / 20;
        t  = one_q30 - ((u2 * t) >> 30) / 6;
        s  = (u * t) >> 30;
        w  = (s * s) >> 30;
        w  = (w + (64'd1 << 14)) >> 15;
        if (w > 64'd32768) begin
            w = 64'd32768;
        end
        return w[15:0];
    endfunction

endpackage

// ===== design/gps_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module gps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/gps_cfg.sv =====
// Configuration register file with wet level limiting.
module gps_cfg
    import gps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wet_level         <= RST_WET_LEVEL;
            r_cfg.pitch_step        <= RST_PITCH_STEP;
            r_cfg.grain_length      <= RST_GRAIN_LENGTH;
            r_cfg.spawn_interval    <= RST_SPAWN_INTERVAL;
            r_cfg.overlap_gain      <= RST_OVERLAP_GAIN;
            r_cfg.length_reciprocal <= RST_LENGTH_RECIP;
        end else if (i_we) begin
            case (t_reg_idx'(i_index))
                REG_WET_LEVEL:      r_cfg.wet_level         <= i_data[16:0];
                REG_PITCH_STEP:     r_cfg.pitch_step        <= i_data[14:0];
                REG_GRAIN_LENGTH:   r_cfg.grain_length      <= i_data[13:0];
                REG_SPAWN_INTERVAL: r_cfg.spawn_interval    <= i_data[15:0];
                REG_OVERLAP_GAIN:   r_cfg.overlap_gain      <= i_data[15:0];
                REG_LENGTH_RECIP:   r_cfg.length_reciprocal <= i_data[23:0];
                default: ;
            endcase
        end
    end

    // limit the mix to fully wet
    always_comb begin
        o_cfg = r_cfg;
        if (r_cfg.wet_level > WET_FULL) begin
            o_cfg.wet_level = WET_FULL;
        end
    end

endmodule

// ===== design/granular_pitch_shifter.sv =====
// Granular pitch shifter top level: delay store, grain walk and output mix.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------
//  input    | i_valid / o_stall      | i_sample_in  (s16)
//  output   | o_valid / i_stall      | o_sample_out (s16)
//  config   | i_cfg_we               | i_cfg_index, i_cfg_data
//
// Each sample is processed by a serial walk over the grain slots; the single read port
// of the delay store serves two reads per active grain.
// Reset is synchronous; unwritten delay entries read as zero through a fill count.
// A new sample is taken while the previous result still waits at the output.
// BUFFER_DEPTH and WINDOW_TABLE_DEPTH must be powers of two; the block does not check this.
module granular_pitch_shifter
    import gps_pkg::*;
#(
    parameter int BUFFER_DEPTH       = 32768,
    parameter int GRAIN_SLOTS        = 16,
    parameter int WINDOW_TABLE_DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int AW      = $clog2(BUFFER_DEPTH);
    localparam int SW      = GRAIN_SLOTS > 1 ? $clog2(GRAIN_SLOTS) : 1;
    localparam int WB      = $clog2(WINDOW_TABLE_DEPTH);
    localparam int GW      = AW + PHASE_W;
    localparam int INT_W   = 30;
    localparam int PROD_W  = 47;
    localparam int ACC_W   = PROD_W + SW + 1;
    localparam int W1      = ACC_W - 26;
    localparam int W2      = W1 + 3;
    localparam int MIX_W   = (W2 + 18 > 34 ? W2 + 18 : 34) + 1;
    localparam int RND_W   = MIX_W - 15;

    typedef logic [15:0] t_win_tab [WINDOW_TABLE_DEPTH];

    function automatic t_win_tab build_win();
        t_win_tab tab;
        for (int k = 0; k < WINDOW_TABLE_DEPTH; k++) begin
            tab[k] = hann_entry(32'(k), WB);
        end
        return tab;
    endfunction

    localparam t_win_tab WIN_TAB = build_win();

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b000000000001,
        ST_SLOT   = 12'b000000000010,
        ST_FETCH  = 12'b000000000100,
        ST_SAMPA  = 12'b000000001000,
        ST_SAMPB  = 12'b000000010000,
        ST_WEIGHT = 12'b000000100000,
        ST_FLUSH  = 12'b000001000000,
        ST_SCALE  = 12'b000010000000,
        ST_GAIN   = 12'b000100000000,
        ST_DRY    = 12'b001000000000,
        ST_WET    = 12'b010000000000,
        ST_DONE   = 12'b100000000000
    } t_state;

    t_cfg cfg;

    gps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    t_state                     r_state, n_state;
    logic [SW-1:0]              r_slot;
    logic [GRAIN_SLOTS-1:0]     r_busy, n_busy;
    logic [AW-1:0]              r_wp;
    logic [AW:0]                r_fill;
    logic [15:0]                r_spawn;
    logic signed [SAMPLE_W-1:0] r_dry;
    logic                       r_out_vld;
    logic signed [SAMPLE_W-1:0] r_out;

    logic [AW-1:0]              r_nxt;
    logic [PH_FRAC-1:0]         r_frac;
    logic [PHASE_W-1:0]         r_ph;
    logic                       r_ok_a, r_ok_b;
    logic [36:0]                r_plo;
    logic [49:0]                r_p;
    logic signed [INT_W-1:0]    r_pa;
    logic signed [INT_W-1:0]    r_interp;
    logic [15:0]                r_win;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_prod_vld;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [W1-1:0]       r_wet1;
    logic signed [W2-1:0]       r_wet2;
    logic signed [MIX_W-1:0]    r_mdry;
    logic signed [MIX_W-1:0]    r_mix;

    logic                  in_acc;
    logic                  last_slot;
    logic [16:0]           cnt_next;
    logic                  spawn;
    logic [SW-1:0]         spawn_slot;
    logic [AW-1:0]         origin_new;

    logic [GW-1:0]         grain_rdata;
    logic                  grain_we;
    logic [SW-1:0]         grain_waddr;
    logic [GW-1:0]         grain_wdata;
    logic [AW-1:0]         g_origin;
    logic [PHASE_W-1:0]    g_ph;
    logic [AW-1:0]         g_idx;
    logic [PHASE_W:0]      g_np;
    logic                  g_end;

    logic [AW-1:0]         dly_raddr;
    logic [SAMPLE_W-1:0]   dly_rdata;
    logic signed [INT_W-1:0] smp_a, smp_b, wt_a, wt_b;
    logic [WB-1:0]         widx;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [ACC_W:0] sc_sum;
    logic signed [W1+17:0] gn_sum;
    logic signed [MIX_W:0] rnd_sum;
    logic signed [RND_W-1:0] mix_rnd;
    logic signed [SAMPLE_W-1:0] sat;
    logic                  out_load;

    assign in_acc    = i_valid && (r_state == ST_IDLE);
    assign o_stall   = (r_state != ST_IDLE);
    assign last_slot = (r_slot == SW'(GRAIN_SLOTS - 1));

    // spawn decision and slot choice
    assign cnt_next   = {1'b0, r_spawn} + 17'd1;
    assign spawn      = (cnt_next >= {1'b0, cfg.spawn_interval});
    assign origin_new = r_wp - AW'(cfg.grain_length);

    always_comb begin
        spawn_slot = '0;
        for (int i = GRAIN_SLOTS - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                spawn_slot = SW'(i);
            end
        end
    end

    // grain word fields and playhead advance
    assign g_origin = grain_rdata[GW-1:PHASE_W];
    assign g_ph     = grain_rdata[PHASE_W-1:0];
    assign g_idx    = g_origin + AW'(g_ph[PHASE_W-1:PH_FRAC]);
    assign g_np     = {1'b0, g_ph} + (PHASE_W+1)'(cfg.pitch_step);
    assign g_end    = (g_np >= {1'b0, cfg.grain_length, {PH_FRAC{1'b0}}});

    always_comb begin
        if (in_acc) begin
            grain_we    = spawn;
            grain_waddr = spawn_slot;
            grain_wdata = {origin_new, {PHASE_W{1'b0}}};
        end else begin
            grain_we    = (r_state == ST_FETCH);
            grain_waddr = r_slot;
            grain_wdata = {g_origin, g_np[PHASE_W-1:0]};
        end
    end

    gps_ram #(
        .WIDTH (GW),
        .DEPTH (GRAIN_SLOTS)
    ) u_grain_ram (
        .i_clk   (i_clk),
        .i_we    (grain_we),
        .i_waddr (grain_waddr),
        .i_wdata (grain_wdata),
        .i_raddr (r_slot),
        .o_rdata (grain_rdata)
    );

    assign dly_raddr = (r_state == ST_FETCH) ? g_idx : r_nxt;

    gps_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_wp),
        .i_wdata (i_sample_in),
        .i_raddr (dly_raddr),
        .o_rdata (dly_rdata)
    );

    // interpolation operands; never-written entries read as zero
    always_comb begin
        smp_a = r_ok_a ? INT_W'($signed(dly_rdata)) : '0;
        smp_b = r_ok_b ? INT_W'($signed(dly_rdata)) : '0;
        wt_a  = INT_W'((PH_FRAC+1)'(13'd4096 - {1'b0, r_frac}));
        wt_b  = INT_W'(r_frac);
        if (r_p[49:36] != '0) begin
            widx = WB'(WINDOW_TABLE_DEPTH - 1);
        end else begin
            widx = r_p[35 -: WB];
        end
        prod_c = PROD_W'(r_interp) * PROD_W'({1'b0, r_win});
    end

    // rounding shifts, ties toward plus infinity
    always_comb begin
        sc_sum  = (ACC_W+1)'(r_acc) + (ACC_W+1)'(64'd1 << 26);
        gn_sum  = (W1+18)'(r_wet1) * (W1+18)'({1'b0, cfg.overlap_gain})
                  + (W1+18)'(64'd1 << 14);
        rnd_sum = (MIX_W+1)'(r_mix) + (MIX_W+1)'(64'd1 << 15);
        mix_rnd = RND_W'(rnd_sum >>> 16);
        if (mix_rnd > RND_W'(32767)) begin
            sat = 16'sd32767;
        end else if (mix_rnd < -RND_W'(32768)) begin
            sat = -16'sd32768;
        end else begin
            sat = SAMPLE_W'(mix_rnd);
        end
    end

    assign out_load = (r_state == ST_DONE) && (!r_out_vld || !i_stall);

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_SLOT;
                    if (spawn) begin
                        n_busy[spawn_slot] = 1'b1;
                    end
                end
            end
            ST_SLOT: begin
                if (r_busy[r_slot]) begin
                    n_state = ST_FETCH;
                end else if (last_slot) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FETCH: begin
                n_state = ST_SAMPA;
                if (g_end) begin
                    n_busy[r_slot] = 1'b0;
                end
            end
            ST_SAMPA:  n_state = ST_SAMPB;
            ST_SAMPB:  n_state = ST_WEIGHT;
            ST_WEIGHT: n_state = last_slot ? ST_FLUSH : ST_SLOT;
            ST_FLUSH:  n_state = ST_SCALE;
            ST_SCALE:  n_state = ST_GAIN;
            ST_GAIN:   n_state = ST_DRY;
            ST_DRY:    n_state = ST_WET;
            ST_WET:    n_state = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_busy     <= '0;
            r_slot     <= '0;
            r_wp       <= '0;
            r_fill     <= '0;
            r_spawn    <= '0;
            r_out_vld  <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_busy     <= n_busy;
            r_prod_vld <= (r_state == ST_WEIGHT);
            if (in_acc) begin
                r_wp    <= r_wp + AW'(1);
                r_slot  <= '0;
                r_spawn <= spawn ? 16'd0 : cnt_next[15:0];
                if (!r_fill[AW]) begin
                    r_fill <= r_fill + (AW+1)'(1);
                end
            end
            if ((r_state == ST_SLOT && !r_busy[r_slot] && !last_slot)
                || (r_state == ST_WEIGHT && !last_slot)) begin
                r_slot <= r_slot + SW'(1);
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dry <= i_sample_in;
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        case (r_state)
            ST_FETCH: begin
                r_ok_a <= r_fill[AW] || ({1'b0, g_idx} < r_fill);
                r_nxt  <= g_idx + AW'(1);
                r_frac <= g_ph[PH_FRAC-1:0];
                r_ph   <= g_ph;
                r_plo  <= 37'(g_ph[12:0]) * 37'(cfg.length_reciprocal);
            end
            ST_SAMPA: begin
                r_ok_b <= r_fill[AW] || ({1'b0, r_nxt} < r_fill);
                r_pa   <= smp_a * wt_a;
                r_p    <= ((50'(r_ph[25:13]) * 50'(cfg.length_reciprocal)) << 13)
                          + 50'(r_plo);
            end
            ST_SAMPB: begin
                r_interp <= r_pa + smp_b * wt_b;
                r_win    <= WIN_TAB[widx];
            end
            ST_WEIGHT: r_prod <= prod_c;
            ST_SCALE:  r_wet1 <= W1'(sc_sum >>> 27);
            ST_GAIN:   r_wet2 <= W2'(gn_sum >>> 15);
            ST_DRY: begin
                r_mdry <= MIX_W'(r_dry) * MIX_W'({1'b0, WET_FULL - cfg.wet_level});
            end
            ST_WET: begin
                r_mix <= r_mdry + MIX_W'(r_wet2) * MIX_W'({1'b0, cfg.wet_level});
            end
            default: ;
        endcase
        if (out_load) begin
            r_out <= sat;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_sample_out = r_out;

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("sample accepted but block did not go busy");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (AW+1)'(BUFFER_DEPTH))
        else $error("fill count beyond delay store depth");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_DONE))
        else $error("result presented outside the final step");

    a_slot_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |-> r_busy[r_slot])
        else $error("idle grain slot fetched");
`endif

endmodule
